/* rtl/core/tcw_pkg.sv */
// Shared constants for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int MODE_W = 2;
  localparam int CLR_W  = 4;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam logic [CLR_W-1:0]  FG_RESET   = 4'hF;
  localparam logic [CLR_W-1:0]  BG_RESET   = 4'h0;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

endpackage

/* rtl/core/tcw_store.sv */
// Screen cell memory: one write port, one registered read port.
module tcw_store
  import tcw_pkg::*;
#(
  parameter int DEPTH  = ROWS_DEF * COLUMNS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/text_console_writer_core.sv */
// Text console writer: screen store, cursor, scroll and clear sequencer.
//
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | one put / clear / read command
//  m_*      | out       | cursor after the command, read cell, scroll flag
//  cfg_*    | in        | foreground (index 0), background (index 1)
//
// Put, carriage return, newline without scroll, read and unused mode go straight
// to the output step. A scroll copies each cell up a row through the single memory
// port pair, one cell per read/write pair, then blanks the bottom row.
// Clear homes the cursor and blanks every cell. After reset a sweep over every cell
// writes blanks; s_tready stays low during it. A waiting result does not block
// the next command; only the final step of a command waits for the output slot.
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_row_out[4:0], cursor_col_out[11:5],
                                 // cell_value[27:12], scrolled[28], zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCRL_RD = 3'd2;
  localparam logic [2:0] S_SCRL_WR = 3'd3;
  localparam logic [2:0] S_FILL    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] idx;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CLR_W-1:0]  fg;
  logic [CLR_W-1:0]  bg;
  logic              scrolled;
  logic              cell_hit;

  logic [MODE_W-1:0] in_mode;
  logic [CHAR_W-1:0] in_char;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              s_fire;
  logic              read_ok;
  logic              last_col;
  logic              last_row;
  logic              out_free;
  logic [ADDR_W-1:0] cursor_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [CELL_W-1:0] blank;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign in_char = s_tdata[7:0];
  assign in_row  = s_tdata[12:8];
  assign in_col  = s_tdata[19:13];
  assign in_mode = s_tuser;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign read_ok  = (in_row < ROW_W'(ROWS)) && (in_col < COL_W'(COLUMNS));
  assign last_col = (cursor_col == COL_W'(COLUMNS - 1));
  assign last_row = (cursor_row == ROW_W'(ROWS - 1));

  assign cursor_addr = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col);
  assign read_addr   = ADDR_W'(in_row) * ADDR_W'(COLUMNS) + ADDR_W'(in_col);
  assign blank       = {bg, fg, CH_SPACE};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = read_addr;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
      end
      S_IDLE: begin
        if (s_fire && in_mode == MODE_PUT && in_char != CH_NEWLINE
            && in_char != CH_RETURN) begin
          mem_we    = 1'b1;
          mem_waddr = cursor_addr;
          mem_wdata = {bg, fg, in_char};
        end
        if (s_fire && in_mode == MODE_READ && read_ok) begin
          mem_re = 1'b1;
        end
      end
      S_SCRL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx + ADDR_W'(COLUMNS);
      end
      S_SCRL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOREGROUND: fg <= cfg_data;
        CFG_BACKGROUND: bg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      idx        <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      scrolled   <= 1'b0;
      cell_hit   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == ADDR_W'(CELLS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            scrolled <= 1'b0;
            cell_hit <= (in_mode == MODE_READ) && read_ok;
            state    <= S_DONE;
            case (in_mode)
              MODE_PUT: begin
                // newline, or a write into the last column, moves down a row (or scrolls on the last row)
                if (in_char == CH_RETURN) begin
                  cursor_col <= '0;
                end else if (in_char == CH_NEWLINE || last_col) begin
                  cursor_col <= '0;
                  if (last_row) begin
                    scrolled <= 1'b1;
                    idx      <= '0;
                    state    <= S_SCRL_RD;
                  end else begin
                    cursor_row <= cursor_row + 1'b1;
                  end
                end else begin
                  cursor_col <= cursor_col + 1'b1;
                end
              end
              MODE_CLEAR: begin
                cursor_row <= '0;
                cursor_col <= '0;
                idx        <= '0;
                state      <= S_FILL;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCRL_RD: begin
          state <= S_SCRL_WR;
        end
        S_SCRL_WR: begin
          idx <= idx + 1'b1;
          // after the last copied cell idx points at the bottom row
          if (idx == ADDR_W'((ROWS - 1) * COLUMNS - 1)) begin
            state <= S_FILL;
          end else begin
            state <= S_SCRL_RD;
          end
        end
        S_FILL: begin
          idx <= idx + 1'b1;
          if (idx == ADDR_W'(CELLS - 1)) begin
            idx   <= '0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, scrolled, (cell_hit ? mem_rdata : {CELL_W{1'b0}}),
                         cursor_col, cursor_row};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
